/* rtl/core/bounded_deque_remove_by_value_macros.svh */
// assertion macros shared by the deque rtl
`ifndef BOUNDED_DEQUE_REMOVE_BY_VALUE_MACROS_SVH
`define BOUNDED_DEQUE_REMOVE_BY_VALUE_MACROS_SVH

// property checked on every edge outside reset
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition on one edge implies consequence on the next edge
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bdq_pkg.sv */
// shared types and constants for the bounded deque
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_DUMP_FWD   = 3'd3,
    ACT_DUMP_REV   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_REMOVE,
    OP_ROT_LEFT,
    OP_ROT_RIGHT
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t                  op;
    logic signed [VALUE_W-1:0] key;
  } cell_ctrl_t;

  // per-cell position flags
  typedef struct packed {
    logic live;
    logic head;
    logic tail;
    logic append;
  } cell_pos_t;

endpackage
`default_nettype wire

/* rtl/core/bdq_cell.sv */
// one element cell of the deque chain
`timescale 1ns / 1ps
`default_nettype none
module bdq_cell (
  input  wire logic                               clk,
  input  wire bdq_pkg::cell_ctrl_t                ctrl_i,
  input  wire bdq_pkg::cell_pos_t                 pos_i,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] left_i,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] right_i,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] head_i,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] tail_i,
  input  wire logic                               found_i,
  output logic                                    found_o,
  output logic signed [bdq_pkg::VALUE_W-1:0]      val_o
);

  logic signed [bdq_pkg::VALUE_W-1:0] val_r;
  logic signed [bdq_pkg::VALUE_W-1:0] val_nxt;

  // first match ripples down the chain
  assign found_o = found_i | (pos_i.live && (val_r == ctrl_i.key));
  assign val_o   = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl_i.op)
      bdq_pkg::OP_PUSH_FRONT: val_nxt = pos_i.head ? ctrl_i.key : left_i;
      bdq_pkg::OP_PUSH_BACK:  if (pos_i.append) val_nxt = ctrl_i.key;
      bdq_pkg::OP_REMOVE:     if (found_o) val_nxt = right_i;
      bdq_pkg::OP_ROT_LEFT:   if (pos_i.live) val_nxt = pos_i.tail ? head_i : right_i;
      bdq_pkg::OP_ROT_RIGHT:  if (pos_i.live) val_nxt = pos_i.head ? tail_i : left_i;
      default:                val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/bounded_deque_remove_by_value.sv */
// top level of the bounded deque with remove by value
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_remove_by_value_macros.svh"
//
//  channel   ports                               handshake
//  request   in_action, in_value                 start high while busy low
//  result    out_status, out_item, out_count,    out_valid, one cycle each
//            out_last
//
//  insert and remove: busy while the request runs in S_EXEC, result registered as it
//    returns to idle; the match search is one compare per cell plus a ripple down the chain
//  dump: busy through S_EXEC and S_DUMP, one element per cycle, set by the chain
//    rotating one place per cycle so that element 0 or the tail sits at the port
//  undefined actions are dropped without a result
//  reset clears the state machine, the element count, the dump index and the result strobe;
//    cell contents stay undefined until written
//  results cannot be stalled: each one is shown for exactly one cycle
module bounded_deque_remove_by_value (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [2:0]                         in_action,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0] in_value,
  output logic                                    out_valid,
  output logic [1:0]                              out_status,
  output logic signed [31:0]                      out_item,
  output logic [bdq_pkg::CNT_W-1:0]               out_count,
  output logic                                    out_last
);

  localparam int N = bdq_pkg::CAPACITY;

  // control state
  bdq_pkg::state_t            state_r, state_nxt;
  logic [bdq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bdq_pkg::IDX_W-1:0]  dmp_r, dmp_nxt;

  // latched request
  bdq_pkg::act_t                      act_r;
  logic signed [bdq_pkg::VALUE_W-1:0] key_r;

  // result register
  logic                               ov_r, ov_nxt;
  bdq_pkg::status_t                   sts_r, sts_nxt;
  logic signed [bdq_pkg::VALUE_W-1:0] item_r, item_nxt;
  logic [bdq_pkg::CNT_W-1:0]          ocnt_r;
  logic                               last_r, last_nxt;

  // chain wiring
  bdq_pkg::cell_ctrl_t                ctrl;
  bdq_pkg::cell_pos_t                 pos   [N];
  logic signed [bdq_pkg::VALUE_W-1:0] vals  [N];
  logic                               found [N+1];
  logic [bdq_pkg::IDX_W-1:0]          tail_idx;
  logic signed [bdq_pkg::VALUE_W-1:0] tail_val;
  logic                               accept;
  logic                               act_ok;
  logic                               empty;
  logic                               full;

  assign tail_idx = cnt_r[bdq_pkg::IDX_W-1:0] - bdq_pkg::IDX_W'(1);
  assign tail_val = vals[tail_idx];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == bdq_pkg::CNT_W'(N));
  assign found[0] = 1'b0;

  // element cells, index 0 is the front of the sequence
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [bdq_pkg::VALUE_W-1:0] left_v;
    logic signed [bdq_pkg::VALUE_W-1:0] right_v;

    assign pos[i].live   = bdq_pkg::CNT_W'(i) < cnt_r;
    assign pos[i].head   = (i == 0);
    assign pos[i].tail   = !empty && (bdq_pkg::IDX_W'(i) == tail_idx);
    assign pos[i].append = (bdq_pkg::CNT_W'(i) == cnt_r);

    if (i == 0) begin : g_first
      assign left_v = tail_val;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    bdq_cell u_cell (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .pos_i   (pos[i]),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (vals[0]),
      .tail_i  (tail_val),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .val_o   (vals[i])
    );
  end

  // only the five defined actions start work
  assign act_ok = (in_action <= 3'(bdq_pkg::ACT_DUMP_REV));
  assign accept = start && !busy;
  assign busy   = (state_r != bdq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
      cnt_r   <= '0;
      dmp_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dmp_r   <= dmp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= bdq_pkg::act_t'(in_action);
      key_r <= in_value;
    end
    sts_r  <= sts_nxt;
    item_r <= item_nxt;
    ocnt_r <= cnt_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dmp_nxt   = dmp_r;
    ctrl.op   = bdq_pkg::OP_HOLD;
    ctrl.key  = key_r;
    ov_nxt    = 1'b0;
    sts_nxt   = bdq_pkg::ST_OK;
    item_nxt  = '0;
    last_nxt  = 1'b0;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (accept && act_ok) state_nxt = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        state_nxt = bdq_pkg::S_IDLE;
        ov_nxt    = 1'b1;
        last_nxt  = 1'b1;
        case (act_r) inside
          bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
            if (full) begin
              sts_nxt = bdq_pkg::ST_FULL;
            end else begin
              ctrl.op = (act_r == bdq_pkg::ACT_PUSH_FRONT) ? bdq_pkg::OP_PUSH_FRONT
                                                           : bdq_pkg::OP_PUSH_BACK;
              cnt_nxt = cnt_r + bdq_pkg::CNT_W'(1);
            end
          end
          bdq_pkg::ACT_REMOVE: begin
            if (empty) begin
              sts_nxt = bdq_pkg::ST_EMPTY;
            end else if (found[N]) begin
              // cells from the first match on take their right neighbor
              ctrl.op = bdq_pkg::OP_REMOVE;
              cnt_nxt = cnt_r - bdq_pkg::CNT_W'(1);
            end else begin
              sts_nxt = bdq_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            // dumps
            if (empty) begin
              sts_nxt = bdq_pkg::ST_EMPTY;
            end else begin
              ov_nxt    = 1'b0;
              last_nxt  = 1'b0;
              dmp_nxt   = '0;
              state_nxt = bdq_pkg::S_DUMP;
            end
          end
        endcase
      end
      bdq_pkg::S_DUMP: begin
        // present one end of the live run and rotate it back into place
        ov_nxt   = 1'b1;
        last_nxt = (dmp_r == tail_idx);
        dmp_nxt  = dmp_r + bdq_pkg::IDX_W'(1);
        if (act_r == bdq_pkg::ACT_DUMP_FWD) begin
          item_nxt = vals[0];
          ctrl.op  = bdq_pkg::OP_ROT_LEFT;
        end else begin
          item_nxt = tail_val;
          ctrl.op  = bdq_pkg::OP_ROT_RIGHT;
        end
        if (last_nxt) state_nxt = bdq_pkg::S_IDLE;
      end
      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  assign out_valid  = ov_r;
  assign out_status = sts_r;
  assign out_item   = item_r;
  assign out_count  = ocnt_r;
  assign out_last   = last_r;

  // element count stays within capacity
  `BDQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= bdq_pkg::CNT_W'(N), "count above capacity")
  // a dump only walks a non-empty store
  `BDQ_ASSERT(a_dump_live, clk, rst_n, (state_r != bdq_pkg::S_DUMP) || !empty, "dump of empty store")
  // empty status always closes the request with a zero count
  `BDQ_ASSERT(a_empty_res, clk, rst_n, !(ov_r && sts_r == bdq_pkg::ST_EMPTY) || (ocnt_r == '0 && last_r), "bad empty result")
  // results of one dump come back to back
  `BDQ_ASSERT_NEXT(a_dump_run, clk, rst_n, ov_r && !last_r, ov_r, "gap inside dump")
  // count only moves together with an ok result
  `BDQ_ASSERT(a_cnt_move, clk, rst_n, !($past(rst_n) && cnt_r != $past(cnt_r)) || (ov_r && sts_r == bdq_pkg::ST_OK), "count changed without ok result")

endmodule
`default_nettype wire

/* sim/deque_result_checker.sv */
`timescale 1ns / 1ps
// reply predictor and checker for the bounded deque, watching both channels
module deque_result_checker
  import bdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [2:0]                in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic [1:0]                out_status,
  input  logic signed [31:0]        out_item,
  input  logic [CNT_W-1:0]          out_count,
  input  logic                      out_last,
  output int                        outstanding,
  output int                        fail_count
);

  typedef struct {
    status_t            status;
    logic signed [31:0] item;
    logic [CNT_W-1:0]   count;
    logic               last;
  } reply_t;

  // shadow ring, front index and element count
  logic signed [VALUE_W-1:0] ring [CAPACITY];
  int head;
  int fill;
  reply_t due_replies[$];

  function automatic logic [IDX_W-1:0] pos(int offset);
    return IDX_W'((head + offset) % CAPACITY);
  endfunction

  function automatic reply_t make_reply(status_t st, logic signed [31:0] it, logic lst);
    reply_t r;
    r.status = st;
    r.item   = it;
    r.count  = fill[CNT_W-1:0];
    r.last   = lst;
    return r;
  endfunction

  task automatic apply_action(logic [2:0] act, logic signed [VALUE_W-1:0] val);
    int hit;
    int off;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill >= CAPACITY) begin
          due_replies.push_back(make_reply(ST_FULL, '0, 1'b1));
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            ring[pos(0)] = val;
          end else begin
            ring[pos(fill)] = val;
          end
          fill++;
          due_replies.push_back(make_reply(ST_OK, '0, 1'b1));
        end
      end
      ACT_REMOVE: begin
        if (fill == 0) begin
          due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
        end else begin
          // first match counted from the front
          hit = fill;
          for (int i = fill - 1; i >= 0; i--)
            if (ring[pos(i)] == val) hit = i;
          if (hit == fill) begin
            due_replies.push_back(make_reply(ST_NOT_FOUND, '0, 1'b1));
          end else begin
            for (int j = hit; j + 1 < fill; j++)
              ring[pos(j)] = ring[pos(j + 1)];
            fill--;
            due_replies.push_back(make_reply(ST_OK, '0, 1'b1));
          end
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_REV: begin
        if (fill == 0) begin
          due_replies.push_back(make_reply(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < fill; i++) begin
            off = (act == ACT_DUMP_FWD) ? i : fill - 1 - i;
            due_replies.push_back(make_reply(ST_OK, ring[pos(off)], i + 1 == fill));
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      head = 0;
      fill = 0;
      fail_count = 0;
      due_replies.delete();
    end else begin
      // replies first: nothing accepted at this edge can answer at it
      if (out_valid) begin
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected reply: status %0d item %0d count %0d last %0b",
                   $time, out_status, out_item, out_count, out_last);
          fail_count++;
        end else begin
          want = due_replies.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_item !== want.item) begin
            $display("%0t: item expected %0d got %0d", $time, want.item, out_item);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $display("%0t: count expected %0d got %0d", $time, want.count, out_count);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) apply_action(in_action, in_value);
    end
    outstanding <= due_replies.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// top of the deque testbench: clock, reset, request stimulus and verdict
module testbench;
  import bdq_pkg::*;

  localparam int ACT_CODES       = 8;    // every code the 3-bit action field can carry
  localparam int RANDOM_REQUESTS = 370;
  localparam int PHASE_LEN       = 50;   // alternate fill-heavy and drain-heavy phases
  localparam int DRAIN_CYCLES    = 40;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic [2:0]                in_action = ACT_PUSH_FRONT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      busy;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic signed [31:0]        out_item;
  logic [CNT_W-1:0]          out_count;
  logic                      out_last;
  int                        outstanding;
  int                        fail_count;

  // when set, the sender never pauses between requests
  logic quiet_run = 1'b0;

  // small pool so removes hit stored values often; the extremes live here too
  logic signed [VALUE_W-1:0] hot_values [8] = '{
    32'sh00000000, 32'shffffffff, 32'sh7fffffff, 32'sh80000000,
    32'sh00000001, 32'sh00000005, 32'sh55555555, 32'shaaaaaaaa
  };

  always #10 clk = ~clk;

  bounded_deque_remove_by_value dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_item   (out_item),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  deque_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_item    (out_item),
    .out_count   (out_count),
    .out_last    (out_last),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // hold start high until the request is taken; busy is sampled at the
  // falling edge, which is the value the rising edge sees
  task automatic send_request(input logic [2:0] act, input logic signed [VALUE_W-1:0] val);
    logic was_busy;
    while (!quiet_run && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
  endtask

  // mostly pool values, otherwise the full 32-bit range
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return hot_values[3'($urandom_range(7))];
    return $urandom();
  endfunction

  initial begin
    int         sent;
    int         roll;
    logic       fill_phase;
    logic [2:0] act;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: both dumps and a remove report empty
    send_request(ACT_DUMP_FWD, 32'sh0);
    send_request(ACT_DUMP_REV, 32'shffffffff);
    send_request(ACT_REMOVE, 32'sh7);

    // extremes at both ends, a front insert wraps the ring below slot zero,
    // and a duplicate zero for the first-match rule
    send_request(ACT_PUSH_FRONT, 32'sh7fffffff);
    send_request(ACT_PUSH_BACK, 32'sh80000000);
    send_request(ACT_PUSH_BACK, 32'sh0);
    send_request(ACT_PUSH_FRONT, 32'shffffffff);
    send_request(ACT_PUSH_BACK, 32'sh0);
    send_request(ACT_DUMP_FWD, 32'sh0);
    send_request(ACT_DUMP_REV, 32'sh0);

    // miss, then remove the first of the two zeros (gap closes toward front)
    send_request(ACT_REMOVE, 32'sh12345);
    send_request(ACT_REMOVE, 32'sh0);

    // undefined actions: dropped without a reply
    for (int a = ACT_DUMP_REV + 1; a < ACT_CODES; a++)
      send_request(a[2:0], $urandom());

    // fill to capacity from both ends, then an insert into the full store
    for (int k = 0; k < 12; k++)
      send_request(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom());
    send_request(ACT_PUSH_BACK, 32'sh1);
    send_request(ACT_DUMP_REV, 32'sh0);

    // random traffic: inserts dominate one phase and removes the next, so
    // the count sweeps between empty and full; one stretch runs back to back
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      quiet_run  = (sent >= 150 && sent < 230);
      fill_phase = ((sent / PHASE_LEN) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_request(3'($urandom_range(ACT_DUMP_REV + 1, ACT_CODES - 1)), $urandom());
      end else begin
        roll = $urandom_range(99);
        if (roll < (fill_phase ? 60 : 25))
          act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else if (roll < 82)
          act = ACT_REMOVE;
        else
          act = $urandom_range(1) ? ACT_DUMP_FWD : ACT_DUMP_REV;
        if (act == ACT_REMOVE && $urandom_range(99) < 85)
          send_request(act, hot_values[3'($urandom_range(7))]);
        else
          send_request(act, pick_value());
        sent++;
      end
    end
    start <= 1'b0;

    // wait for every predicted reply, then let the block settle
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // watchdog: the slowest legal run is a small fraction of this
  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
